### design/set_assoc_fifo_cache_tag_sim_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the set-associative tag cache
// Shared property shorthands, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef SET_ASSOC_FIFO_CACHE_TAG_SIM_MACROS_SVH
`define SET_ASSOC_FIFO_CACHE_TAG_SIM_MACROS_SVH

// same-cycle implication
`define SAFC_ASSERT_IMP(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("cache tag check failed");

// next-cycle implication
`define SAFC_ASSERT_NXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("cache tag check failed");

`endif

### design/safc_pkg.sv
// ----------------------------------------------------------------------------
// safc_pkg
// Fixed widths and helpers of the set-associative tag cache.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package safc_pkg;

	localparam int ADDR_W  = 32;
	localparam int CNT_W   = 32;
	localparam int WAY_W   = 2;
	localparam int IN_W    = 32;
	// hit, way, hit_count, miss_count = 67 bits, padded to 72
	localparam int OUT_RAW_W = 1 + WAY_W + CNT_W + CNT_W;
	localparam int OUT_W     = 72;
	localparam int PAD_W     = OUT_W - OUT_RAW_W;

	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	// floor(log2(v)), v >= 1
	function automatic int floor_log2(input int v);
		int n;
		int x;
		n = 0;
		x = v;
		while (x > 1) begin
			x = x >> 1;
			n = n + 1;
		end
		return n;
	endfunction

endpackage

### design/set_assoc_fifo_cache_tag_sim.sv
// ----------------------------------------------------------------------------
// set_assoc_fifo_cache_tag_sim
// Tag-only set-associative cache with FIFO replacement and hit/miss counters.
// ----------------------------------------------------------------------------
// Channel  Dir  tdata fields (lsb up)                        tuser  tlast
// s_axis   in   address[31:0]                                -      -
// m_axis   out  hit, way[1:0], hit_count[31:0],              -      -
//               miss_count[31:0], zero pad to 72 bits
//
// One access per cycle sustained while m_axis accepts. The accepting edge reads
// the set's row from the set memory; the compare stage compares it and, when it
// retires, writes back and registers the result, which raises m_axis_tvalid.
// Back-to-back accesses to the same set take the just-written row from a bypass.
// Reset clears the per-set row valid flops at once; no clearing pass.
// A stalled m_axis holds the compare stage, which then holds s_axis_tready low.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "set_assoc_fifo_cache_tag_sim_macros.svh"

module set_assoc_fifo_cache_tag_sim #(
	parameter int NUM_SETS   = 8,
	parameter int NUM_WAYS   = 4,
	parameter int LINE_BYTES = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [safc_pkg::IN_W-1:0]   s_axis_tdata,   // address[31:0]
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	output logic [safc_pkg::OUT_W-1:0]  m_axis_tdata    // hit, way, hit_count, miss_count, pad
);

	localparam int OFF_W = safc_pkg::floor_log2(LINE_BYTES);
	localparam int SET_W = safc_pkg::floor_log2(NUM_SETS);
	localparam int TAG_W = safc_pkg::ADDR_W - OFF_W - SET_W;
	localparam int ROWS  = 1 << SET_W;
	localparam int PTR_W = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(NUM_WAYS - 1);

	typedef logic [NUM_WAYS-1:0][TAG_W-1:0] tag_row_t;

	// set memory: tags of all ways, plus FIFO pointer and full flag
	tag_row_t          tag_mem  [ROWS];
	logic [PTR_W-1:0]  ptr_mem  [ROWS];
	logic              full_mem [ROWS];
	logic [ROWS-1:0]   row_valid_q;

	logic              in_fire;
	logic              s1_fire;
	logic [SET_W-1:0]  in_set;

	logic              valid_s1;
	logic              rvalid_s1;
	logic              byp_s1;
	logic [SET_W-1:0]  set_s1;
	logic [TAG_W-1:0]  tag_s1;
	tag_row_t          rd_tags_s1;
	logic [PTR_W-1:0]  rd_ptr_s1;
	logic              rd_full_s1;
	tag_row_t          byp_tags_s1;
	logic [PTR_W-1:0]  byp_ptr_s1;
	logic              byp_full_s1;

	tag_row_t          cur_tags;
	logic [PTR_W-1:0]  cur_ptr;
	logic              cur_full;
	logic              hit_c;
	logic [PTR_W-1:0]  hit_way_c;
	tag_row_t          new_tags;
	logic [PTR_W-1:0]  new_ptr;
	logic              new_full;

	logic                             out_valid_q;
	logic                             out_hit_q;
	logic [safc_pkg::WAY_W-1:0]       out_way_q;
	logic [safc_pkg::CNT_W-1:0]       hit_cnt_q;
	logic [safc_pkg::CNT_W-1:0]       miss_cnt_q;

	assign in_set        = s_axis_tdata[OFF_W +: SET_W];
	assign s1_fire       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || s1_fire;
	assign in_fire       = s_axis_tvalid && s_axis_tready;

	// compare stage
	always_comb begin
		if (byp_s1) begin
			cur_tags = byp_tags_s1;
			cur_ptr  = byp_ptr_s1;
			cur_full = byp_full_s1;
		end else if (rvalid_s1) begin
			cur_tags = rd_tags_s1;
			cur_ptr  = rd_ptr_s1;
			cur_full = rd_full_s1;
		end else begin
			cur_tags = rd_tags_s1;
			cur_ptr  = '0;
			cur_full = 1'b0;
		end

		// ways fill in order, so way w is valid if full or below the pointer
		hit_c     = 1'b0;
		hit_way_c = '0;
		for (int w = NUM_WAYS - 1; w >= 0; w--) begin
			if ((cur_full || (w < int'(cur_ptr))) && cur_tags[w] == tag_s1) begin
				hit_c     = 1'b1;
				hit_way_c = PTR_W'(w);
			end
		end

		new_tags = cur_tags;
		new_ptr  = cur_ptr;
		new_full = cur_full;
		if (!hit_c) begin
			new_tags[cur_ptr] = tag_s1;
			new_ptr           = (cur_ptr == PTR_LAST) ? '0 : cur_ptr + 1'b1;
			new_full          = cur_full || (cur_ptr == PTR_LAST);
		end
	end

	// memory: read on acceptance, write back when the compare stage retires
	always_ff @(posedge clk) begin
		if (in_fire) begin
			rd_tags_s1 <= tag_mem[in_set];
			rd_ptr_s1  <= ptr_mem[in_set];
			rd_full_s1 <= full_mem[in_set];
		end
		if (s1_fire) begin
			tag_mem[set_s1]  <= new_tags;
			ptr_mem[set_s1]  <= new_ptr;
			full_mem[set_s1] <= new_full;
		end
	end

	// payload of the compare stage and bypass row, and the registered hit and way
	always_ff @(posedge clk) begin
		if (in_fire) begin
			set_s1      <= in_set;
			tag_s1      <= s_axis_tdata[safc_pkg::ADDR_W-1 -: TAG_W];
			byp_tags_s1 <= new_tags;
			byp_ptr_s1  <= new_ptr;
			byp_full_s1 <= new_full;
		end
		if (s1_fire) begin
			out_hit_q <= hit_c;
			out_way_q <= hit_c ? safc_pkg::WAY_W'(hit_way_c) : safc_pkg::WAY_W'(cur_ptr);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			rvalid_s1   <= 1'b0;
			byp_s1      <= 1'b0;
			row_valid_q <= '0;
			out_valid_q <= 1'b0;
			hit_cnt_q   <= '0;
			miss_cnt_q  <= '0;
		end else begin
			if (in_fire) begin
				valid_s1  <= 1'b1;
				// same set as the row being written this edge: take it from the bypass
				byp_s1    <= s1_fire && (in_set == set_s1);
				rvalid_s1 <= row_valid_q[in_set];
			end else if (s1_fire) begin
				valid_s1 <= 1'b0;
			end

			if (s1_fire) begin
				row_valid_q[set_s1] <= 1'b1;
				out_valid_q         <= 1'b1;
				if (hit_c) begin
					if (hit_cnt_q != safc_pkg::CNT_MAX) hit_cnt_q <= hit_cnt_q + 1'b1;
				end else begin
					if (miss_cnt_q != safc_pkg::CNT_MAX) miss_cnt_q <= miss_cnt_q + 1'b1;
				end
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{safc_pkg::PAD_W{1'b0}}, miss_cnt_q, hit_cnt_q, out_way_q, out_hit_q};

	`SAFC_ASSERT_IMP(a_stall_blocks_input, valid_s1 && out_valid_q && !m_axis_tready, !s_axis_tready)
	`SAFC_ASSERT_NXT(a_row_marked_valid, s1_fire, row_valid_q[$past(set_s1)])
	`SAFC_ASSERT_NXT(a_hit_count_mono, 1'b1, hit_cnt_q >= $past(hit_cnt_q))
	`SAFC_ASSERT_NXT(a_miss_count_step, s1_fire && !hit_c && miss_cnt_q != safc_pkg::CNT_MAX, miss_cnt_q == $past(miss_cnt_q) + 1'b1)

endmodule
